/* rtl/core/mbc_pkg.sv */
`default_nettype none

package mbc_pkg;

    localparam int ROUNDS     = 32;
    localparam int HALF_W     = 32;
    localparam int BLOCK_W    = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int KEY_WORDS  = 8;
    localparam int REV_MIN    = 8;
    localparam int REV_MAX    = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_01   = 3'd0,
        CFG_KEY_23   = 3'd1,
        CFG_KEY_45   = 3'd2,
        CFG_KEY_67   = 3'd3,
        CFG_DECRYPT  = 3'd4
    } t_cfg_index;

    typedef logic [3:0] t_sbox_row [16];

    localparam t_sbox_row SBOX [8] = '{
        '{4'd12, 4'd4, 4'd6, 4'd2, 4'd10, 4'd5, 4'd11, 4'd9,
          4'd14, 4'd8, 4'd13, 4'd7, 4'd0, 4'd3, 4'd15, 4'd1},
        '{4'd6, 4'd8, 4'd2, 4'd3, 4'd9, 4'd10, 4'd5, 4'd12,
          4'd1, 4'd14, 4'd4, 4'd7, 4'd11, 4'd13, 4'd0, 4'd15},
        '{4'd11, 4'd3, 4'd5, 4'd8, 4'd2, 4'd15, 4'd10, 4'd13,
          4'd14, 4'd1, 4'd7, 4'd4, 4'd12, 4'd9, 4'd6, 4'd0},
        '{4'd12, 4'd8, 4'd2, 4'd1, 4'd13, 4'd4, 4'd15, 4'd6,
          4'd7, 4'd0, 4'd10, 4'd5, 4'd3, 4'd14, 4'd9, 4'd11},
        '{4'd7, 4'd15, 4'd5, 4'd10, 4'd8, 4'd1, 4'd6, 4'd13,
          4'd0, 4'd9, 4'd3, 4'd14, 4'd11, 4'd4, 4'd2, 4'd12},
        '{4'd5, 4'd13, 4'd15, 4'd6, 4'd9, 4'd2, 4'd12, 4'd10,
          4'd11, 4'd7, 4'd8, 4'd1, 4'd4, 4'd3, 4'd14, 4'd0},
        '{4'd8, 4'd14, 4'd2, 4'd5, 4'd6, 4'd9, 4'd1, 4'd12,
          4'd15, 4'd4, 4'd11, 4'd0, 4'd13, 4'd10, 4'd3, 4'd7},
        '{4'd1, 4'd7, 4'd14, 4'd13, 4'd0, 4'd5, 4'd8, 4'd3,
          4'd4, 4'd15, 4'd10, 4'd6, 4'd9, 4'd12, 4'd11, 4'd2}
    };

    function automatic logic [HALF_W-1:0] round_f(input logic [HALF_W-1:0] half,
                                                  input logic [HALF_W-1:0] key);
        logic [HALF_W-1:0] v;
        logic [HALF_W-1:0] s;
        v = half + key;
        for (int i = 0; i < 8; i++) begin
            s[4*i +: 4] = SBOX[i][v[4*i +: 4]];
        end
        return {s[HALF_W-12:0], s[HALF_W-1:HALF_W-11]};
    endfunction

endpackage

`default_nettype wire

/* rtl/core/mbc_round.sv */
`default_nettype none

module mbc_round
    import mbc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire logic [HALF_W-1:0] i_lo,
    input  wire logic [HALF_W-1:0] i_hi,
    input  wire logic [HALF_W-1:0] i_key,
    output logic                   o_valid,
    output logic      [HALF_W-1:0] o_lo,
    output logic      [HALF_W-1:0] o_hi
);

    logic              r_valid;
    logic [HALF_W-1:0] r_lo;
    logic [HALF_W-1:0] r_hi;
    logic [HALF_W-1:0] n_lo;

    assign n_lo = i_hi ^ round_f(i_lo, i_key);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // swap halves
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lo <= n_lo;
            r_hi <= i_lo;
        end
    end

    assign o_valid = r_valid;
    assign o_lo    = r_lo;
    assign o_hi    = r_hi;

endmodule

`default_nettype wire

/* rtl/core/magma_block_cipher.sv */
// Pipeline: one register stage per round from input transaction to result.
// Throughput: one block per cycle while the result is not stalled; each stage holds one add, S-box layer and XOR.
// A stalled result freezes the whole round pipeline in place.
// Reset (synchronous, active low) clears all stage valid bits, zeroes the key
// and selects the encrypt key order.
`default_nettype none

module magma_block_cipher
    import mbc_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [BLOCK_W-1:0]   i_block_in,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic      [BLOCK_W-1:0]   o_block_out,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [BLOCK_W-1:0]   i_cfg_data
);

    logic [HALF_W-1:0] r_key [KEY_WORDS];
    logic              r_decrypt;
    logic              en;

    logic              vld [ROUNDS+1];
    logic [HALF_W-1:0] lo  [ROUNDS+1];
    logic [HALF_W-1:0] hi  [ROUNDS+1];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < KEY_WORDS; k++) begin
                r_key[k] <= '0;
            end
            r_decrypt <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_KEY_01: begin
                    r_key[0] <= i_cfg_data[HALF_W-1:0];
                    r_key[1] <= i_cfg_data[BLOCK_W-1:HALF_W];
                end
                CFG_KEY_23: begin
                    r_key[2] <= i_cfg_data[HALF_W-1:0];
                    r_key[3] <= i_cfg_data[BLOCK_W-1:HALF_W];
                end
                CFG_KEY_45: begin
                    r_key[4] <= i_cfg_data[HALF_W-1:0];
                    r_key[5] <= i_cfg_data[BLOCK_W-1:HALF_W];
                end
                CFG_KEY_67: begin
                    r_key[6] <= i_cfg_data[HALF_W-1:0];
                    r_key[7] <= i_cfg_data[BLOCK_W-1:HALF_W];
                end
                CFG_DECRYPT: begin
                    r_decrypt <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    // hold every stage while the result waits
    assign en         = !(o_out_valid && i_out_stall);
    assign o_in_stall = !en;

    assign vld[0] = i_in_valid;
    assign lo[0]  = i_block_in[HALF_W-1:0];
    assign hi[0]  = i_block_in[BLOCK_W-1:HALF_W];

    for (genvar r = 0; r < ROUNDS; r++) begin : g_round
        localparam int FWD = r % KEY_WORDS;
        localparam int REV = KEY_WORDS - 1 - FWD;
        logic [HALF_W-1:0] key;

        if (r < REV_MIN) begin : g_rev
            assign key = r_key[REV];
        end else if (r < REV_MAX) begin : g_mode
            assign key = r_decrypt ? r_key[FWD] : r_key[REV];
        end else begin : g_fwd
            assign key = r_key[FWD];
        end

        mbc_round u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (vld[r]),
            .i_lo    (lo[r]),
            .i_hi    (hi[r]),
            .i_key   (key),
            .o_valid (vld[r+1]),
            .o_lo    (lo[r+1]),
            .o_hi    (hi[r+1])
        );
    end

    // undo the swap of the last round
    assign o_out_valid = vld[ROUNDS];
    assign o_block_out = {lo[ROUNDS], hi[ROUNDS]};

endmodule

`default_nettype wire

/* rtl/core/mbc_checker.sv */
`default_nettype none

module mbc_checker
    import mbc_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_in_stall,
    input wire logic               o_out_valid,
    input wire logic               i_out_stall,
    input wire logic [BLOCK_W-1:0] o_block_out,
    input wire logic               o_cfg_ready
);

    a_stall_cause: assert property (@(posedge i_clk)
        o_in_stall == (o_out_valid && i_out_stall))
        else $error("input stall without a waiting result");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_block_out))
        else $error("stalled result changed");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("configuration port not ready");

endmodule

bind magma_block_cipher mbc_checker u_mbc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_block_out (o_block_out),
    .o_cfg_ready (o_cfg_ready)
);

`default_nettype wire

/* tb/tb_magma_block_cipher.sv */
`default_nettype none

module tb_magma_block_cipher;
    import mbc_pkg::*;

    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 40;
    localparam int QUIET_LIMIT   = 2000;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 170;
    localparam int IDLE_PCT      = 22;
    localparam int ENC_REV_ROUNDS = 24;
    localparam int DEC_REV_ROUNDS = 8;
    localparam int DIRECTED_N    = 12;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED_LO = CFG_IDX_W'(CFG_DECRYPT + 1);
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED_HI = {CFG_IDX_W{1'b1}};

    localparam logic [3:0] MAGMA_SBOX [8][16] = '{
        '{12, 4, 6, 2, 10, 5, 11, 9, 14, 8, 13, 7, 0, 3, 15, 1},
        '{6, 8, 2, 3, 9, 10, 5, 12, 1, 14, 4, 7, 11, 13, 0, 15},
        '{11, 3, 5, 8, 2, 15, 10, 13, 14, 1, 7, 4, 12, 9, 6, 0},
        '{12, 8, 2, 1, 13, 4, 15, 6, 7, 0, 10, 5, 3, 14, 9, 11},
        '{7, 15, 5, 10, 8, 1, 6, 13, 0, 9, 3, 14, 11, 4, 2, 12},
        '{5, 13, 15, 6, 9, 2, 12, 10, 11, 7, 8, 1, 4, 3, 14, 0},
        '{8, 14, 2, 5, 6, 9, 1, 12, 15, 4, 11, 0, 13, 10, 3, 7},
        '{1, 7, 14, 13, 0, 5, 8, 3, 4, 15, 10, 6, 9, 12, 11, 2}
    };

    localparam logic [BLOCK_W-1:0] DIRECTED_BLOCKS [DIRECTED_N] = '{
        64'h0000_0000_0000_0000,
        64'hFFFF_FFFF_FFFF_FFFF,
        64'h0000_0000_FFFF_FFFF,
        64'hFFFF_FFFF_0000_0000,
        64'h0000_0000_0000_0001,
        64'h8000_0000_0000_0000,
        64'h0000_0001_8000_0000,
        64'h5555_5555_5555_5555,
        64'hAAAA_AAAA_AAAA_AAAA,
        64'h0123_4567_89AB_CDEF,
        64'hFEDC_BA98_7654_3210,
        64'h0F0F_F0F0_F0F0_0F0F
    };

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic [BLOCK_W-1:0]   i_block_in  = '0;
    logic                 i_out_stall = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [BLOCK_W-1:0]   i_cfg_data  = '0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    logic [BLOCK_W-1:0]   o_block_out;
    logic                 o_cfg_ready;

    magma_block_cipher i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_block_in  (i_block_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_block_out (o_block_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    logic [BLOCK_W-1:0] key_store [4];
    bit                 decrypt_order;
    logic [BLOCK_W-1:0] predicted_blocks [$];
    logic [BLOCK_W-1:0] captured_cipher [$];
    logic [BLOCK_W-1:0] roundtrip_plain [$];
    bit                 capture_on;
    int                 fault_count;
    int                 quiet_cycles;
    int                 in_idle_pct;
    int                 out_idle_pct;
    logic [BLOCK_W-1:0] want_block;
    logic [BLOCK_W-1:0] want_plain;

    initial begin
        key_store     = '{default: '0};
        decrypt_order = 1'b0;
        capture_on    = 1'b0;
        fault_count   = 0;
        quiet_cycles  = 0;
        in_idle_pct   = IDLE_PCT;
        out_idle_pct  = IDLE_PCT;
    end

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [HALF_W-1:0] sched_key(input int r);
        int rev;
        int w;
        rev = decrypt_order ? DEC_REV_ROUNDS : ENC_REV_ROUNDS;
        w   = (r < rev) ? 7 - (r % 8) : r % 8;
        return w[0] ? key_store[w >> 1][63:32] : key_store[w >> 1][31:0];
    endfunction

    function automatic logic [HALF_W-1:0] mix_half(input logic [HALF_W-1:0] half,
                                                   input logic [HALF_W-1:0] k);
        logic [HALF_W-1:0] sum;
        logic [HALF_W-1:0] sub;
        int n;
        sum = half + k;
        for (n = 0; n < 8; n++) begin
            sub[4*n +: 4] = MAGMA_SBOX[n][sum[4*n +: 4]];
        end
        return {sub[20:0], sub[31:21]};
    endfunction

    function automatic logic [BLOCK_W-1:0] magma_transform(input logic [BLOCK_W-1:0] blk);
        logic [HALF_W-1:0] lo;
        logic [HALF_W-1:0] hi;
        logic [HALF_W-1:0] t;
        int r;
        lo = blk[31:0];
        hi = blk[63:32];
        for (r = 0; r < ROUNDS - 1; r++) begin
            t  = hi ^ mix_half(lo, sched_key(r));
            hi = lo;
            lo = t;
        end
        hi = hi ^ mix_half(lo, sched_key(ROUNDS - 1));
        return {hi, lo};
    endfunction

    function automatic logic [BLOCK_W-1:0] pick_block();
        if ($urandom_range(7) == 0) begin
            return DIRECTED_BLOCKS[$urandom_range(DIRECTED_N - 1)];
        end
        return {$urandom, $urandom};
    endfunction

    function automatic logic [BLOCK_W-1:0] pick_key();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_KEY_01:  key_store[0] = i_cfg_data;
                    CFG_KEY_23:  key_store[1] = i_cfg_data;
                    CFG_KEY_45:  key_store[2] = i_cfg_data;
                    CFG_KEY_67:  key_store[3] = i_cfg_data;
                    CFG_DECRYPT: decrypt_order = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_in_valid && !o_in_stall) begin
                predicted_blocks.push_back(magma_transform(i_block_in));
            end
            if (o_out_valid && !i_out_stall) begin
                if (predicted_blocks.size() == 0) begin
                    fault_count++;
                    $display("%0t: block_out %h with no transaction pending",
                             $time, o_block_out);
                end else begin
                    want_block = predicted_blocks.pop_front();
                    if (o_block_out !== want_block) begin
                        fault_count++;
                        $display("%0t: block_out expected %h actual %h",
                                 $time, want_block, o_block_out);
                    end
                    if (capture_on) begin
                        captured_cipher.push_back(o_block_out);
                    end
                    if (roundtrip_plain.size() != 0) begin
                        want_plain = roundtrip_plain.pop_front();
                        if (o_block_out !== want_plain) begin
                            fault_count++;
                            $display("%0t: decrypted block expected %h actual %h",
                                     $time, want_plain, o_block_out);
                        end
                    end
                end
            end
        end
    end

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < out_idle_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
    end

    // Enter and leave at a falling edge.
    task automatic send_block(input logic [BLOCK_W-1:0] blk);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_block_in <= blk;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [BLOCK_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        do @(negedge i_clk); while (predicted_blocks.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic program_cipher(input logic [BLOCK_W-1:0] k01, input logic [BLOCK_W-1:0] k23,
                                  input logic [BLOCK_W-1:0] k45, input logic [BLOCK_W-1:0] k67,
                                  input logic [BLOCK_W-1:0] mode);
        cfg_write(CFG_KEY_01, k01);
        cfg_write(CFG_KEY_23, k23);
        cfg_write(CFG_KEY_45, k45);
        cfg_write(CFG_KEY_67, k67);
        cfg_write(CFG_DECRYPT, mode);
        if ($urandom_range(1)) begin
            cfg_write(t_cfg_idx'($urandom_range(CFG_IDX_UNUSED_HI, CFG_IDX_UNUSED_LO)),
                      {$urandom, $urandom});
        end
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int ph;
        int n;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Encrypt under the reset key, then decrypt the captured ciphertext.
        capture_on = 1'b1;
        for (n = 0; n < DIRECTED_N; n++) begin
            send_block(DIRECTED_BLOCKS[n]);
        end
        i_in_valid <= 1'b0;
        wait_drained();
        capture_on = 1'b0;
        cfg_write(CFG_DECRYPT, '1);
        cfg_write(CFG_IDX_UNUSED_LO, '1);
        cfg_write(CFG_IDX_UNUSED_HI, '1);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
        for (n = 0; n < DIRECTED_N; n++) begin
            roundtrip_plain.push_back(DIRECTED_BLOCKS[n]);
        end
        while (captured_cipher.size() != 0) begin
            send_block(captured_cipher.pop_front());
        end
        i_in_valid <= 1'b0;
        wait_drained();

        for (ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: program_cipher('1, '1, '1, '1, 64'hFFFF_FFFF_FFFF_FFFE);
                1: program_cipher('1, '1, '1, '1, 64'h0000_0000_0000_0001);
                2: program_cipher('0, '0, '0, '0, 64'h8000_0000_0000_0001);
                default: program_cipher(pick_key(), pick_key(), pick_key(), pick_key(),
                                        {$urandom, $urandom});
            endcase
            in_idle_pct  = (ph == 3) ? 0 : IDLE_PCT;
            out_idle_pct = (ph == 3) ? 0 : IDLE_PCT;
            @(negedge i_clk);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 5 && n == PHASE_ITEMS / 2) begin
                    // Hold the sender until the pipeline is empty.
                    i_in_valid <= 1'b0;
                    wait_drained();
                end
                send_block(pick_block());
            end
            i_in_valid <= 1'b0;
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fault_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
